// ----- rtl/core/rpr_pkg.sv -----
// ----------------------------------------------------------------------------
// rpr_pkg
// Types, frame constants and helpers shared by the polled port reporter.
// ----------------------------------------------------------------------------
package rpr_pkg;

    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] STATION_RESET = 8'h51;
    localparam logic [7:0] TAG_RESET = 8'h52;

    localparam int REPLY_LEN = 12;
    localparam int IDX_W = 4;

    localparam logic [0:0] REG_STATION = 1'b0;
    localparam logic [0:0] REG_TAG = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [7:0] port_a;
        logic [7:0] port_b;
        logic [7:0] port_c;
        logic [7:0] port_d;
    } item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } reply_byte_t;

    typedef struct packed {
        logic [7:0]  station;
        logic [7:0]  tag;
        logic [31:0] ports;
    } reply_info_t;

    typedef struct packed {
        logic        valid;
        reply_info_t info;
    } reply_req_t;

    typedef struct packed {
        logic [7:0] station_address;
        logic [7:0] reply_tag;
    } cfg_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10)
            hex_digit = ASCII_ZERO + wide;
        else
            hex_digit = ASCII_UPPER_A + wide - 8'd10;
    endfunction

endpackage

// ----- rtl/core/rs485_polled_port_reporter.sv -----
// ----------------------------------------------------------------------------
// rs485_polled_port_reporter
// Polled bus slave: parses received frames and answers its station address
// with a twelve-byte report of four input ports in ASCII hex.
//
// Usage:
//   item channel: one received byte plus the four port values per
//   transaction (item_valid / item_stall). Bytes outside a frame other than
//   STX are dropped; the frame state updates at each accepted transaction.
//   reply channel: reply bytes one per transaction (reply_valid /
//   reply_stall), last set on the closing ETX.
//   Config: APB registers, station address at 0x0, reply tag at 0x4.
//   Throughput: one item per cycle while item_stall is low; a reply goes
//   out as twelve bytes, one per cycle from the output register unless stalled.
//   After the edge that accepts the ETX item, the first reply byte passes
//   through the pending slot (loaded at that edge), then the active slot,
//   then the output register.
//   item_stall is high while a reply sits in the pending slot.
//   When the receiver stalls, the output byte holds and the replies queue
//   in the two slots; items stop while the pending slot is full.
//   Reset clears frame tracking and all queued replies; registers return
//   to address 0x51 and tag 0x52.
// ----------------------------------------------------------------------------
module rs485_polled_port_reporter
#(
    parameter int MAX_FRAME = 14
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  rpr_pkg::item_t        item,
    output logic                  reply_valid,
    input  logic                  reply_stall,
    output rpr_pkg::reply_byte_t  reply,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    rpr_pkg::cfg_t       cfg;
    rpr_pkg::reply_req_t req;
    logic                busy;
    logic                accept;

    assign item_stall = busy;
    assign accept     = item_valid && !busy;

    rpr_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rpr_parser #(.MAX_FRAME(MAX_FRAME)) u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg),
        .req    (req)
    );

    rpr_serializer u_ser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .busy        (busy),
        .reply_valid (reply_valid),
        .reply_stall (reply_stall),
        .reply       (reply)
    );

endmodule

// ----- rtl/core/rpr_cfg.sv -----
// ----------------------------------------------------------------------------
// rpr_cfg
// APB register file holding the station address and the reply tag.
// ----------------------------------------------------------------------------
module rpr_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output rpr_pkg::cfg_t      cfg
);

    logic [7:0] station_reg;
    logic [7:0] station_next;
    logic [7:0] tag_reg;
    logic [7:0] tag_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        station_next = station_reg;
        tag_next     = tag_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                rpr_pkg::REG_STATION: station_next = pwdata[7:0];
                rpr_pkg::REG_TAG:     tag_next     = pwdata[7:0];
                default:              station_next = station_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg <= rpr_pkg::STATION_RESET;
            tag_reg     <= rpr_pkg::TAG_RESET;
        end
        else
        begin
            station_reg <= station_next;
            tag_reg     <= tag_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            rpr_pkg::REG_STATION: prdata = {24'h0, station_reg};
            rpr_pkg::REG_TAG:     prdata = {24'h0, tag_reg};
            default:              prdata = 32'h0;
        endcase
    end

    assign cfg.station_address = station_reg;
    assign cfg.reply_tag       = tag_reg;

endmodule

// ----- rtl/core/rpr_parser.sv -----
// ----------------------------------------------------------------------------
// rpr_parser
// Frame tracker: hunts for STX, keeps the target address, closes on ETX or at
// the length limit and raises a reply request when the frame names this station.
// ----------------------------------------------------------------------------
module rpr_parser
#(
    parameter int MAX_FRAME = 14
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  rpr_pkg::item_t      item,
    input  rpr_pkg::cfg_t       cfg,
    output rpr_pkg::reply_req_t req
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic             in_frame_reg;
    logic             in_frame_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       target_reg;
    logic [7:0]       target_next;
    logic [CNT_W-1:0] count_inc;
    logic [7:0]       target_eff;
    logic             hit;

    assign count_inc  = count_reg + CNT_ONE;
    assign target_eff = (count_reg == CNT_ONE) ? item.rx_byte : target_reg;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        target_next   = target_reg;
        hit           = 1'b0;
        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (item.rx_byte == rpr_pkg::STX_BYTE)
                begin
                    in_frame_next = 1'b1;
                    count_next    = CNT_ONE;
                end
            end
            else
            begin
                target_next = target_eff;
                if (item.rx_byte != rpr_pkg::ETX_BYTE)
                begin
                    if (count_inc >= CNT_MAX)
                    begin
                        in_frame_next = 1'b0;
                        count_next    = '0;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                else
                begin
                    in_frame_next = 1'b0;
                    count_next    = '0;
                    hit           = (target_eff == cfg.station_address);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            target_reg   <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            target_reg   <= target_next;
        end
    end

    assign req.valid        = hit;
    assign req.info.station = cfg.station_address;
    assign req.info.tag     = cfg.reply_tag;
    assign req.info.ports   = {item.port_a, item.port_b, item.port_c, item.port_d};

endmodule

// ----- rtl/core/rpr_serializer.sv -----
// ----------------------------------------------------------------------------
// rpr_serializer
// Holds one pending reply and one reply in progress, and sends the twelve
// reply bytes one per cycle while the output is not stalled, through a registered output.
// ----------------------------------------------------------------------------
module rpr_serializer
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  rpr_pkg::reply_req_t       req,
    output logic                      busy,
    output logic                      reply_valid,
    input  logic                      reply_stall,
    output rpr_pkg::reply_byte_t      reply
);

    localparam logic [rpr_pkg::IDX_W-1:0] IDX_LAST =
        rpr_pkg::IDX_W'(rpr_pkg::REPLY_LEN - 1);

    logic                       pend_valid_reg;
    logic                       pend_valid_next;
    rpr_pkg::reply_info_t       pend_reg;
    rpr_pkg::reply_info_t       pend_next;
    logic                       cur_valid_reg;
    logic                       cur_valid_next;
    rpr_pkg::reply_info_t       cur_reg;
    rpr_pkg::reply_info_t       cur_next;
    logic [rpr_pkg::IDX_W-1:0]  idx_reg;
    logic [rpr_pkg::IDX_W-1:0]  idx_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    rpr_pkg::reply_byte_t       out_reg;
    rpr_pkg::reply_byte_t       out_next;
    logic                       out_adv;
    logic                       finish;
    logic                       xfer;
    logic [7:0]                 cur_byte;

    assign out_adv = !out_valid_reg || !reply_stall;
    assign finish  = cur_valid_reg && out_adv && (idx_reg == IDX_LAST);
    assign xfer    = pend_valid_reg && (!cur_valid_reg || finish);

    always_comb
    begin
        case (idx_reg)
            4'd0:    cur_byte = rpr_pkg::STX_BYTE;
            4'd1:    cur_byte = cur_reg.station;
            4'd2:    cur_byte = cur_reg.tag;
            4'd3:    cur_byte = rpr_pkg::hex_digit(cur_reg.ports[31:28]);
            4'd4:    cur_byte = rpr_pkg::hex_digit(cur_reg.ports[27:24]);
            4'd5:    cur_byte = rpr_pkg::hex_digit(cur_reg.ports[23:20]);
            4'd6:    cur_byte = rpr_pkg::hex_digit(cur_reg.ports[19:16]);
            4'd7:    cur_byte = rpr_pkg::hex_digit(cur_reg.ports[15:12]);
            4'd8:    cur_byte = rpr_pkg::hex_digit(cur_reg.ports[11:8]);
            4'd9:    cur_byte = rpr_pkg::hex_digit(cur_reg.ports[7:4]);
            4'd10:   cur_byte = rpr_pkg::hex_digit(cur_reg.ports[3:0]);
            default: cur_byte = rpr_pkg::ETX_BYTE;
        endcase
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cur_valid_next  = cur_valid_reg;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        if (out_adv)
        begin
            out_valid_next = cur_valid_reg;
            if (cur_valid_reg)
            begin
                out_next.tx_byte = cur_byte;
                out_next.last    = (idx_reg == IDX_LAST);
                idx_next         = idx_reg + 1'b1;
            end
        end

        if (finish)
            cur_valid_next = 1'b0;

        if (xfer)
        begin
            cur_valid_next  = 1'b1;
            cur_next        = pend_reg;
            idx_next        = '0;
            pend_valid_next = 1'b0;
        end

        if (req.valid)
        begin
            pend_valid_next = 1'b1;
            pend_next       = req.info;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            cur_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            cur_valid_reg  <= cur_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        cur_reg  <= cur_next;
        out_reg  <= out_next;
    end

    assign busy        = pend_valid_reg;
    assign reply_valid = out_valid_reg;
    assign reply       = out_reg;

endmodule

// ----- rtl/core/rpr_checker.sv -----
// ----------------------------------------------------------------------------
// rpr_checker
// Port-level checks on the reply stream of the polled port reporter.
// ----------------------------------------------------------------------------
module rpr_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 reply_valid,
    input logic                 reply_stall,
    input rpr_pkg::reply_byte_t reply
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && reply_stall |=> reply_valid && $stable(reply))
        else $error("stalled reply transaction changed");

    a_last_etx: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && reply.last |-> reply.tx_byte == rpr_pkg::ETX_BYTE)
        else $error("last reply byte is not ETX");

    a_next_stx: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && !reply_stall && reply.last
        |=> !reply_valid || reply.tx_byte == rpr_pkg::STX_BYTE)
        else $error("reply following a closed reply does not start with STX");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !reply_valid)
        else $error("reply valid during reset");

endmodule

bind rs485_polled_port_reporter rpr_checker u_rpr_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .reply_valid (reply_valid),
    .reply_stall (reply_stall),
    .reply       (reply)
);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polled port reporter. Received bytes go in
// with random port values and random gaps; reply bytes are taken under random
// stall and checked byte by byte against a frame parser kept in step here.
// A directed table covers reset values, the port extremes and the framing
// corner cases. Random frames then run under several address and tag settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAME_LIMIT = 14;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES = 5;
    localparam int PHASE_ITEMS = 15;
    localparam int NUM_ROWS = 25;
    localparam logic [2:0] ADDR_STATION = {rpr_pkg::REG_STATION, 2'b00};
    localparam logic [2:0] ADDR_TAG = {rpr_pkg::REG_TAG, 2'b00};

    typedef struct packed {
        rpr_pkg::item_t pkt;
        logic           typed;
        logic           has_reply;
        logic [95:0]    tx;
    } directed_row_t;

    typedef rpr_pkg::reply_byte_t [rpr_pkg::REPLY_LEN-1:0] reply_frame_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    rpr_pkg::item_t       item = '0;
    logic                 reply_valid;
    logic                 reply_stall = 1'b0;
    rpr_pkg::reply_byte_t reply;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // parser state kept in step with the block
    logic        frame_open;
    int          frame_len;
    logic [7:0]  addr_seen;
    logic [7:0]  station_addr;
    logic [7:0]  tag_value;

    rpr_pkg::reply_byte_t expected_reply_q [$];
    int          errors;
    int          items_sent;
    int          frames_sent;
    int          replies_seen;
    int          settings_used;
    int          stall_left;
    int          idle_cycles;
    bit          send_burst;
    bit          reply_burst;

    directed_row_t directed_rows [NUM_ROWS] = '{
        '{'{8'h55, 8'h12, 8'h34, 8'h56, 8'h78}, 1'b1, 1'b0, 96'h0},
        '{'{rpr_pkg::STX_BYTE, 8'h9a, 8'hbc, 8'hde, 8'hf0}, 1'b0, 1'b0, 96'h0},
        '{'{8'h51, 8'h01, 8'h23, 8'h45, 8'h67}, 1'b0, 1'b0, 96'h0},
        '{'{rpr_pkg::ETX_BYTE, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 1'b1,
          96'h02_51_52_30_30_30_30_30_30_30_30_03},
        '{'{rpr_pkg::STX_BYTE, 8'ha5, 8'h5a, 8'h3c, 8'hc3}, 1'b0, 1'b0, 96'h0},
        '{'{8'h51, 8'h0f, 8'hf0, 8'h96, 8'h69}, 1'b0, 1'b0, 96'h0},
        '{'{rpr_pkg::STX_BYTE, 8'h11, 8'h22, 8'h33, 8'h44}, 1'b0, 1'b0, 96'h0},
        '{'{rpr_pkg::ETX_BYTE, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, 1'b1,
          96'h02_51_52_46_46_46_46_46_46_46_46_03},
        '{'{rpr_pkg::STX_BYTE, 8'h5a, 8'h6b, 8'h7c, 8'h8d}, 1'b0, 1'b0, 96'h0},
        '{'{rpr_pkg::ETX_BYTE, 8'h89, 8'hab, 8'hcd, 8'hef}, 1'b1, 1'b0, 96'h0},
        '{'{rpr_pkg::STX_BYTE, 8'h01, 8'h02, 8'h04, 8'h08}, 1'b0, 1'b0, 96'h0},
        '{'{8'h51, 8'h10, 8'h20, 8'h40, 8'h80}, 1'b0, 1'b0, 96'h0},
        '{'{8'h00, 8'hfe, 8'hfd, 8'hfb, 8'hf7}, 1'b0, 1'b0, 96'h0},
        '{'{8'hff, 8'hef, 8'hdf, 8'hbf, 8'h7f}, 1'b0, 1'b0, 96'h0},
        '{'{8'h04, 8'h3a, 8'hb4, 8'h5c, 8'hd6}, 1'b0, 1'b0, 96'h0},
        '{'{8'h80, 8'h7e, 8'he7, 8'h18, 8'h81}, 1'b0, 1'b0, 96'h0},
        '{'{8'h7f, 8'h24, 8'h42, 8'hdb, 8'hbd}, 1'b0, 1'b0, 96'h0},
        '{'{rpr_pkg::STX_BYTE, 8'h99, 8'h66, 8'hcc, 8'h33}, 1'b0, 1'b0, 96'h0},
        '{'{8'h51, 8'h0a, 8'hb0, 8'hc1, 8'h2d}, 1'b0, 1'b0, 96'h0},
        '{'{8'haa, 8'he5, 8'h5e, 8'h07, 8'h70}, 1'b0, 1'b0, 96'h0},
        '{'{8'h55, 8'h19, 8'h91, 8'hab, 8'hba}, 1'b0, 1'b0, 96'h0},
        '{'{8'h01, 8'h8f, 8'hf8, 8'h4e, 8'he4}, 1'b0, 1'b0, 96'h0},
        '{'{8'hfe, 8'h2b, 8'hb2, 8'h6d, 8'hd6}, 1'b0, 1'b0, 96'h0},
        '{'{8'hc0, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, 1'b0, 96'h0},
        '{'{rpr_pkg::ETX_BYTE, 8'h10, 8'h20, 8'h30, 8'h40}, 1'b1, 1'b0, 96'h0}
    };

    rs485_polled_port_reporter #(
        .MAX_FRAME(FRAME_LIMIT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .reply_valid(reply_valid),
        .reply_stall(reply_stall),
        .reply(reply),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] nibble_to_ascii(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + 8'(nib);
        return 8'h41 + 8'(nib) - 8'd10;
    endfunction

    function automatic rpr_pkg::item_t with_ports(input logic [7:0] rx);
        rpr_pkg::item_t it;
        it.rx_byte = rx;
        it.port_a = 8'($urandom_range(0, 255));
        it.port_b = 8'($urandom_range(0, 255));
        it.port_c = 8'($urandom_range(0, 255));
        it.port_d = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        if ($urandom_range(0, 7) == 0)
            return rpr_pkg::STX_BYTE;
        do
            b = 8'($urandom_range(0, 255));
        while (b == rpr_pkg::ETX_BYTE);
        return b;
    endfunction

    // advances the parser by one received byte, returns the reply it causes
    task automatic predict_reply(input rpr_pkg::item_t it, output bit emits,
                                 output reply_frame_t frame);
        logic [31:0] ports;
        emits = 1'b0;
        frame = '0;
        if (!frame_open)
        begin
            if (it.rx_byte == rpr_pkg::STX_BYTE)
            begin
                frame_open = 1'b1;
                frame_len = 1;
            end
        end
        else
        begin
            if (frame_len == 1)
                addr_seen = it.rx_byte;
            frame_len++;
            if (it.rx_byte != rpr_pkg::ETX_BYTE)
            begin
                if (frame_len >= FRAME_LIMIT)
                begin
                    frame_open = 1'b0;
                    frame_len = 0;
                end
            end
            else
            begin
                frame_open = 1'b0;
                frame_len = 0;
                if (addr_seen == station_addr)
                begin
                    emits = 1'b1;
                    ports = {it.port_a, it.port_b, it.port_c, it.port_d};
                    frame[0] = '{rpr_pkg::STX_BYTE, 1'b0};
                    frame[1] = '{station_addr, 1'b0};
                    frame[2] = '{tag_value, 1'b0};
                    for (int k = 0; k < 8; k++)
                        frame[3+k] = '{nibble_to_ascii(ports[31-4*k -: 4]), 1'b0};
                    frame[rpr_pkg::REPLY_LEN-1] = '{rpr_pkg::ETX_BYTE, 1'b1};
                end
            end
        end
    endtask

    task automatic send_item(input rpr_pkg::item_t it, input bit typed,
                             input bit has_reply, input logic [95:0] typed_tx);
        int gap;
        bit emits;
        reply_frame_t frame;
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        items_sent++;
        predict_reply(it, emits, frame);
        if (typed)
        begin
            emits = has_reply;
            for (int k = 0; k < rpr_pkg::REPLY_LEN; k++)
                frame[k] = '{typed_tx[95-8*k -: 8], k == rpr_pkg::REPLY_LEN - 1};
        end
        if (emits)
            for (int k = 0; k < rpr_pkg::REPLY_LEN; k++)
                expected_reply_q.push_back(frame[k]);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reg_check(input logic [2:0] addr, input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata[7:0] !== value)
        begin
            $display("%0t register %0d: expected %h, got %h", $time, addr, value,
                     prdata[7:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setting(input logic [7:0] station, input logic [7:0] tag);
        reg_write(ADDR_STATION, {24'h0, station});
        reg_write(ADDR_TAG, {24'h0, tag});
        station_addr = station;
        tag_value = tag;
        reg_check(ADDR_STATION, station);
        reg_check(ADDR_TAG, tag);
        settings_used++;
    endtask

    // holds the item side until every reply is out and the block is quiet
    task automatic settle();
        item_valid <= 1'b0;
        wait (expected_reply_q.size() == 0);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_frame(output int counted);
        int kind;
        int body_len;
        int pick;
        logic [7:0] addr;
        logic [7:0] closing;
        send_burst = ($urandom_range(0, 3) == 0);
        kind = $urandom_range(0, 9);
        counted = 0;
        if (kind == 0)
        begin
            send_item(with_ports(8'($urandom_range(0, 255))), 1'b0, 1'b0, '0);
            counted = 1;
            return;
        end
        pick = $urandom_range(0, 9);
        if (pick < 7)
            addr = station_addr;
        else if (pick == 7)
            addr = rpr_pkg::ETX_BYTE;
        else
            addr = 8'($urandom_range(0, 255));
        // broken frames run to the length limit and may end without ETX
        body_len = (kind == 1) ? FRAME_LIMIT - 3 : $urandom_range(0, 6);
        closing = (kind == 1 && $urandom_range(0, 1) == 0) ? body_byte()
                                                           : rpr_pkg::ETX_BYTE;
        send_item(with_ports(rpr_pkg::STX_BYTE), 1'b0, 1'b0, '0);
        send_item(with_ports(addr), 1'b0, 1'b0, '0);
        for (int k = 0; k < body_len; k++)
            send_item(with_ports(body_byte()), 1'b0, 1'b0, '0);
        send_item(with_ports(closing), 1'b0, 1'b0, '0);
        frames_sent++;
        counted = body_len + 3;
    endtask

    // reply side: checks each transaction and draws the next stall
    always @(posedge clk)
    begin
        rpr_pkg::reply_byte_t want;
        int wait_draw;
        if (rst_n && reply_valid && !reply_stall)
        begin
            replies_seen++;
            if (expected_reply_q.size() == 0)
            begin
                $display("%0t unexpected reply: expected none, got tx_byte=%h last=%b",
                         $time, reply.tx_byte, reply.last);
                errors++;
            end
            else
            begin
                want = expected_reply_q.pop_front();
                if (reply.tx_byte !== want.tx_byte)
                begin
                    $display("%0t tx_byte: expected %h, got %h", $time, want.tx_byte,
                             reply.tx_byte);
                    errors++;
                end
                if (reply.last !== want.last)
                begin
                    $display("%0t last: expected %b, got %b", $time, want.last,
                             reply.last);
                    errors++;
                end
            end
            wait_draw = reply_burst ? 0 : $urandom_range(0, 15);
            stall_left <= wait_draw;
            reply_stall <= (wait_draw > 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            reply_stall <= (stall_left > 1);
        end
        else
        begin
            reply_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (reply_valid && !reply_stall) ||
                (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("rs485_polled_port_reporter: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int phase_items;
        int counted;
        logic [7:0] station;
        logic [7:0] tag;
        frame_open = 1'b0;
        frame_len = 0;
        addr_seen = '0;
        station_addr = rpr_pkg::STATION_RESET;
        tag_value = rpr_pkg::TAG_RESET;
        errors = 0;
        items_sent = 0;
        frames_sent = 0;
        replies_seen = 0;
        settings_used = 1;
        stall_left = 0;
        idle_cycles = 0;
        send_burst = 1'b0;
        reply_burst = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            send_burst = ($urandom_range(0, 2) == 0);
            send_item(directed_rows[r].pkt, directed_rows[r].typed,
                      directed_rows[r].has_reply, directed_rows[r].tx);
        end
        settle();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    station = 8'h00;
                    tag = 8'h00;
                end
                1:
                begin
                    station = 8'hff;
                    tag = 8'hff;
                end
                2:
                begin
                    station = rpr_pkg::ETX_BYTE;
                    tag = 8'($urandom_range(0, 255));
                end
                3:
                begin
                    station = 8'($urandom_range(0, 255));
                    tag = 8'($urandom_range(0, 255));
                end
                default:
                begin
                    station = rpr_pkg::STATION_RESET;
                    tag = rpr_pkg::TAG_RESET;
                end
            endcase
            apply_setting(station, tag);
            reply_burst = ($urandom_range(0, 2) == 0);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                run_random_frame(counted);
                phase_items += counted;
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d input transactions (%0d random frames), checked %0d reply bytes",
                 items_sent, frames_sent, replies_seen);
        $display("address and tag settings exercised: %0d", settings_used);
        if (errors == 0 && expected_reply_q.size() == 0)
            $display("rs485_polled_port_reporter: match");
        else
            $display("rs485_polled_port_reporter: mismatch");
        $finish;
    end

endmodule
